FILE: rtl/core/qstr_pkg.sv
package qstr_pkg;

	// Fixed formats of the stream and the timing loop
	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 24;
	localparam int GAIN_W     = 24;
	localparam int GPER_W     = 23;
	localparam int SPS_W      = 7;
	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int SUM_W      = SAMPLE_W + 3;
	localparam int ERR_W      = 28;
	localparam int ERR_SHIFT  = SAMPLE_W - 1;
	localparam int PER_W      = SPS_W + FRAC_W;
	localparam int OFS_W      = 32;
	localparam int CLAMP_W    = 33;
	localparam int MA_W       = GAIN_W + 1;
	localparam int MB_W       = ERR_W;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// 1/sqrt(2) in Q0.24
	localparam logic [GAIN_W-1:0] INV_SQRT2_Q24 = 24'd11863283;

	// Register reset values
	localparam logic [SPS_W-1:0]  SPS_RST        = 7'd4;
	localparam logic [GAIN_W-1:0] GAIN_PHASE_RST = 24'd838861;
	localparam logic [GPER_W-1:0] GAIN_PER_RST   = 23'd10486;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPS         = 2'd0,
		CFG_GAIN_PHASE  = 2'd1,
		CFG_GAIN_PERIOD = 2'd2
	} qstr_cfg_reg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_first;
		logic take_skip;
		logic take_strobe;
		logic mul_i;
		logic mul_q;
		logic fin_q;
		logic mul_err;
		logic rnd_err;
		logic mul_per;
		logic upd_per;
		logic mul_adv;
		logic commit;
	} qstr_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic have_raw;
		logic strobe_due;
		logic out_full;
	} qstr_stat_t;

endpackage

FILE: rtl/core/qpsk_symbol_timing_recovery.sv
// Mueller-Muller symbol timing recovery for a QPSK baseband stream. Each input
// word is one complex sample (I low, Q high, Q1.15). The first sample after reset
// is only stored. Whenever the fractional strobe falls between the previous and
// the current sample, one linearly interpolated symbol leaves on the master side
// with tlast set; at two or more samples per symbol at most one symbol comes per
// sample. A sample without a strobe is taken straight from idle; a sample with a
// strobe holds off the next sample while the single 25x28 multiplier is used five
// times in turn (two interpolations, the timing error, the period and the phase
// update) and while it waits for the output register. Writing samples_per_symbol
// (index 0) also reloads the period estimate; gains sit at index 1 (phase) and
// 2 (period). Write configuration only while the block is idle.
module qpsk_symbol_timing_recovery (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,   // sample_i, sample_q
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,   // symbol_i, symbol_q
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qstr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qstr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SW = qstr_pkg::SAMPLE_W;

	qstr_pkg::qstr_cmd_t  cmd;
	qstr_pkg::qstr_stat_t stat;
	logic [SW-1:0]        sym_i;
	logic [SW-1:0]        sym_q;

	assign cfg_ready = 1'b1;

	qstr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	qstr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_sample_i  (s_axis_tdata[SW-1:0]),
		.in_sample_q  (s_axis_tdata[2*SW-1:SW]),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_symbol_i (sym_i),
		.out_symbol_q (sym_q)
	);

	assign m_axis_tdata = {sym_q, sym_i};

	// each sample yields at most one symbol, so every word closes its sample
	assign m_axis_tlast = 1'b1;

endmodule

FILE: rtl/core/qstr_ctrl.sv
module qstr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  qstr_pkg::qstr_stat_t  stat,
	output qstr_pkg::qstr_cmd_t   cmd
);

	typedef enum logic [9:0] {
		ST_IDLE    = 10'b0000000001,
		ST_MUL_I   = 10'b0000000010,
		ST_MUL_Q   = 10'b0000000100,
		ST_FIN_Q   = 10'b0000001000,
		ST_MUL_ERR = 10'b0000010000,
		ST_RND_ERR = 10'b0000100000,
		ST_MUL_PER = 10'b0001000000,
		ST_UPD_PER = 10'b0010000000,
		ST_MUL_ADV = 10'b0100000000,
		ST_COMMIT  = 10'b1000000000
	} qstr_state_t;

	qstr_state_t state_q;
	qstr_state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Sequence one strobe through the shared multiplier
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (!stat.have_raw) begin
						cmd.take_first = 1'b1;
					end else if (!stat.strobe_due) begin
						cmd.take_skip = 1'b1;
					end else begin
						cmd.take_strobe = 1'b1;
						state_nxt       = ST_MUL_I;
					end
				end
			end
			ST_MUL_I: begin
				cmd.mul_i = 1'b1;
				state_nxt = ST_MUL_Q;
			end
			ST_MUL_Q: begin
				cmd.mul_q = 1'b1;
				state_nxt = ST_FIN_Q;
			end
			ST_FIN_Q: begin
				cmd.fin_q = 1'b1;
				state_nxt = ST_MUL_ERR;
			end
			ST_MUL_ERR: begin
				cmd.mul_err = 1'b1;
				state_nxt   = ST_RND_ERR;
			end
			ST_RND_ERR: begin
				cmd.rnd_err = 1'b1;
				state_nxt   = ST_MUL_PER;
			end
			ST_MUL_PER: begin
				cmd.mul_per = 1'b1;
				state_nxt   = ST_UPD_PER;
			end
			ST_UPD_PER: begin
				cmd.upd_per = 1'b1;
				state_nxt   = ST_MUL_ADV;
			end
			ST_MUL_ADV: begin
				cmd.mul_adv = 1'b1;
				state_nxt   = ST_COMMIT;
			end
			ST_COMMIT: begin
				// hold until the output register can take the word
				if (!stat.out_full) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: rtl/core/qstr_dp.sv
module qstr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [qstr_pkg::SAMPLE_W-1:0]       in_sample_i,
	input  logic [qstr_pkg::SAMPLE_W-1:0]       in_sample_q,
	input  logic                                cfg_valid,
	input  logic [qstr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [qstr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  qstr_pkg::qstr_cmd_t                 cmd,
	output qstr_pkg::qstr_stat_t                stat,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [qstr_pkg::SAMPLE_W-1:0]       out_symbol_i,
	output logic [qstr_pkg::SAMPLE_W-1:0]       out_symbol_q
);

	localparam int SW = qstr_pkg::SAMPLE_W;
	localparam int FW = qstr_pkg::FRAC_W;
	localparam int PW = qstr_pkg::PROD_W;
	localparam int CW = qstr_pkg::CLAMP_W;
	localparam logic [qstr_pkg::OFS_W-1:0] ONE = qstr_pkg::OFS_W'(1) << FW;
	localparam logic signed [PW-1:0] RND_FRAC = PW'(1) << (FW - 1);
	localparam logic signed [PW-1:0] RND_ERR  = PW'(1) << (qstr_pkg::ERR_SHIFT - 1);

	// Configuration
	logic [qstr_pkg::SPS_W-1:0]  sps_q;
	logic [qstr_pkg::GAIN_W-1:0] gain_ph_q;
	logic [qstr_pkg::GPER_W-1:0] gain_per_q;

	// Loop state
	logic                          have_raw_q;
	logic [qstr_pkg::OFS_W-1:0]    offset_q;
	logic [qstr_pkg::PER_W-1:0]    period_q;
	logic signed [SW-1:0]          earlier_i_q;
	logic signed [SW-1:0]          earlier_q_q;
	logic signed [SW-1:0]          last_i_q;
	logic signed [SW-1:0]          last_q_q;
	logic                          last_neg_i_q;
	logic                          last_neg_q_q;
	logic                          dec_present_q;

	// Working registers
	logic signed [SW-1:0]              cur_i_q;
	logic signed [SW-1:0]              cur_q_q;
	logic signed [SW-1:0]              si_q;
	logic signed [SW-1:0]              sq_q;
	logic signed [PW-1:0]              prod_q;
	logic signed [qstr_pkg::ERR_W-1:0] err_q;

	logic                          out_valid_q;
	logic [SW-1:0]                 out_i_q;
	logic [SW-1:0]                 out_q_q;

	function automatic logic [qstr_pkg::SPS_W-1:0] eff_sps(
		input logic [qstr_pkg::SPS_W-1:0] s
	);
		logic [qstr_pkg::SPS_W-1:0] r;
		if (s < 7'd2) begin
			r = 7'd2;
		end else if (s > 7'd64) begin
			r = 7'd64;
		end else begin
			r = s;
		end
		return r;
	endfunction

	// Clamp bounds from the effective samples per symbol
	logic [qstr_pkg::SPS_W-1:0] sps_eff;
	logic signed [CW-1:0]       lim_lo;
	logic signed [CW-1:0]       lim_per_hi;
	logic signed [CW-1:0]       lim_adv_hi;
	logic [qstr_pkg::SPS_W+1:0] sps_x3;

	assign sps_eff    = eff_sps(sps_q);
	assign sps_x3     = {2'b00, sps_eff} + {1'b0, sps_eff, 1'b0};
	assign lim_lo     = $signed(CW'({sps_eff, {(FW - 1){1'b0}}}));
	assign lim_per_hi = $signed(CW'({sps_x3, {(FW - 1){1'b0}}}));
	assign lim_adv_hi = $signed(CW'({sps_eff, {(FW + 1){1'b0}}}));

	// Interpolation differences
	logic signed [qstr_pkg::DIFF_W-1:0] diff_i;
	logic signed [qstr_pkg::DIFF_W-1:0] diff_q;

	assign diff_i = $signed({cur_i_q[SW-1], cur_i_q}) - $signed({earlier_i_q[SW-1], earlier_i_q});
	assign diff_q = $signed({cur_q_q[SW-1], cur_q_q}) - $signed({earlier_q_q[SW-1], earlier_q_q});

	// Mueller-Muller sum: pd*cs - cd*ps per rail
	logic signed [qstr_pkg::SUM_W-1:0] si_x;
	logic signed [qstr_pkg::SUM_W-1:0] sq_x;
	logic signed [qstr_pkg::SUM_W-1:0] li_x;
	logic signed [qstr_pkg::SUM_W-1:0] lq_x;
	logic signed [qstr_pkg::SUM_W-1:0] t_pi;
	logic signed [qstr_pkg::SUM_W-1:0] t_pq;
	logic signed [qstr_pkg::SUM_W-1:0] t_ci;
	logic signed [qstr_pkg::SUM_W-1:0] t_cq;
	logic signed [qstr_pkg::SUM_W-1:0] mm_sum;

	assign si_x   = qstr_pkg::SUM_W'(si_q);
	assign sq_x   = qstr_pkg::SUM_W'(sq_q);
	assign li_x   = qstr_pkg::SUM_W'(last_i_q);
	assign lq_x   = qstr_pkg::SUM_W'(last_q_q);
	assign t_pi   = !dec_present_q ? '0 : (last_neg_i_q ? -si_x : si_x);
	assign t_pq   = !dec_present_q ? '0 : (last_neg_q_q ? -sq_x : sq_x);
	assign t_ci   = si_q[SW-1] ? li_x : -li_x;
	assign t_cq   = sq_q[SW-1] ? lq_x : -lq_x;
	assign mm_sum = t_pi + t_pq + t_ci + t_cq;

	// Shared multiplier operands
	logic signed [qstr_pkg::MA_W-1:0] mul_a;
	logic signed [qstr_pkg::MB_W-1:0] mul_b;
	logic signed [PW-1:0]             mul_res;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (cmd.mul_i) begin
			mul_a = $signed({1'b0, offset_q[FW-1:0]});
			mul_b = qstr_pkg::MB_W'(diff_i);
		end else if (cmd.mul_q) begin
			mul_a = $signed({1'b0, offset_q[FW-1:0]});
			mul_b = qstr_pkg::MB_W'(diff_q);
		end else if (cmd.mul_err) begin
			mul_a = $signed({1'b0, qstr_pkg::INV_SQRT2_Q24});
			mul_b = qstr_pkg::MB_W'(mm_sum);
		end else if (cmd.mul_per) begin
			mul_a = $signed({2'b00, gain_per_q});
			mul_b = err_q;
		end else begin
			mul_a = $signed({1'b0, gain_ph_q});
			mul_b = err_q;
		end
	end

	assign mul_res = mul_a * mul_b;

	// Round half up of the registered product
	logic signed [PW-1:0] rnd_frac;
	logic signed [PW-1:0] rnd_err;

	assign rnd_frac = (prod_q + RND_FRAC) >>> FW;
	assign rnd_err  = (prod_q + RND_ERR) >>> qstr_pkg::ERR_SHIFT;

	// Interpolated rail from the earlier sample
	logic signed [SW:0] interp_i;
	logic signed [SW:0] interp_q;

	assign interp_i = $signed({earlier_i_q[SW-1], earlier_i_q}) + rnd_frac[SW:0];
	assign interp_q = $signed({earlier_q_q[SW-1], earlier_q_q}) + rnd_frac[SW:0];

	// Period update and strobe advance, both clamped
	logic signed [CW-1:0] per_sum;
	logic signed [CW-1:0] per_clamp;
	logic signed [CW-1:0] adv_sum;
	logic signed [CW-1:0] adv_clamp;
	logic [qstr_pkg::OFS_W-1:0] offset_adv;

	assign per_sum = $signed({2'b00, period_q}) + rnd_frac[CW-1:0];
	assign adv_sum = $signed({2'b00, period_q}) + rnd_frac[CW-1:0];

	always_comb begin
		priority if (per_sum < lim_lo) begin
			per_clamp = lim_lo;
		end else if (per_sum > lim_per_hi) begin
			per_clamp = lim_per_hi;
		end else begin
			per_clamp = per_sum;
		end
		priority if (adv_sum < lim_lo) begin
			adv_clamp = lim_lo;
		end else if (adv_sum > lim_adv_hi) begin
			adv_clamp = lim_adv_hi;
		end else begin
			adv_clamp = adv_sum;
		end
	end

	assign offset_adv = offset_q + adv_clamp[qstr_pkg::OFS_W-1:0] - ONE;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q      <= qstr_pkg::SPS_RST;
			gain_ph_q  <= qstr_pkg::GAIN_PHASE_RST;
			gain_per_q <= qstr_pkg::GAIN_PER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qstr_pkg::CFG_SPS:         sps_q      <= cfg_data[qstr_pkg::SPS_W-1:0];
				qstr_pkg::CFG_GAIN_PHASE:  gain_ph_q  <= cfg_data[qstr_pkg::GAIN_W-1:0];
				qstr_pkg::CFG_GAIN_PERIOD: gain_per_q <= cfg_data[qstr_pkg::GPER_W-1:0];
				default: ;
			endcase
		end
	end

	// Loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_raw_q    <= 1'b0;
			offset_q      <= '0;
			period_q      <= {qstr_pkg::SPS_RST, {FW{1'b0}}};
			earlier_i_q   <= '0;
			earlier_q_q   <= '0;
			last_i_q      <= '0;
			last_q_q      <= '0;
			last_neg_i_q  <= 1'b0;
			last_neg_q_q  <= 1'b0;
			dec_present_q <= 1'b0;
		end else begin
			// load the period along with samples per symbol
			if (cfg_valid && cfg_index == qstr_pkg::CFG_SPS) begin
				period_q <= {eff_sps(cfg_data[qstr_pkg::SPS_W-1:0]), {FW{1'b0}}};
			end else if (cmd.upd_per) begin
				period_q <= per_clamp[qstr_pkg::PER_W-1:0];
			end
			if (cmd.take_first) begin
				have_raw_q  <= 1'b1;
				earlier_i_q <= in_sample_i;
				earlier_q_q <= in_sample_q;
			end
			if (cmd.take_skip) begin
				offset_q    <= offset_q - ONE;
				earlier_i_q <= in_sample_i;
				earlier_q_q <= in_sample_q;
			end
			if (cmd.commit) begin
				offset_q      <= offset_adv;
				earlier_i_q   <= cur_i_q;
				earlier_q_q   <= cur_q_q;
				last_i_q      <= si_q;
				last_q_q      <= sq_q;
				last_neg_i_q  <= si_q[SW-1];
				last_neg_q_q  <= sq_q[SW-1];
				dec_present_q <= 1'b1;
			end
		end
	end

	// Working registers of one strobe
	always_ff @(posedge clk) begin
		if (cmd.take_strobe) begin
			cur_i_q <= in_sample_i;
			cur_q_q <= in_sample_q;
		end
		if (cmd.mul_i || cmd.mul_q || cmd.mul_err || cmd.mul_per || cmd.mul_adv) begin
			prod_q <= mul_res;
		end
		if (cmd.mul_q) begin
			si_q <= interp_i[SW-1:0];
		end
		if (cmd.fin_q) begin
			sq_q <= interp_q[SW-1:0];
		end
		if (cmd.rnd_err) begin
			err_q <= rnd_err[qstr_pkg::ERR_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_i_q <= si_q;
			out_q_q <= sq_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_symbol_i = out_i_q;
	assign out_symbol_q = out_q_q;

	assign stat.have_raw   = have_raw_q;
	assign stat.strobe_due = (offset_q < ONE);
	assign stat.out_full   = out_valid_q && !out_ready;

endmodule

FILE: tb/qpsk_symbol_timing_recovery_tb.sv
`timescale 1ns / 1ps

module qpsk_symbol_timing_recovery_tb;

	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 24;
	localparam longint ONE_UI   = longint'(1) << qstr_pkg::FRAC_W;

	// unmapped register index, the block ignores a write to it
	localparam logic [qstr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [qstr_pkg::SAMPLE_W-1:0] sym_i;
		logic [qstr_pkg::SAMPLE_W-1:0] sym_q;
		logic                          last;
	} symbol_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [31:0]                     s_axis_tdata = '0;     // sample_i, sample_q
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [31:0]                     m_axis_tdata;          // symbol_i, symbol_q
	logic                            m_axis_tlast;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [qstr_pkg::CFG_IDX_W-1:0]  cfg_index = qstr_pkg::CFG_SPS;
	logic [qstr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0] samples_pending[$];
	symbol_t     symbols_due[$];
	int          errors = 0;
	bit          quiet = 1'b0;
	int unsigned in_pause = 0;
	int unsigned out_pause = 0;
	int unsigned out_draw;
	int unsigned idle_cycles = 0;

	// timing loop state as the block should hold it
	logic [qstr_pkg::SPS_W-1:0]  sps_reg = qstr_pkg::SPS_RST;
	logic [qstr_pkg::GAIN_W-1:0] gain_phase = qstr_pkg::GAIN_PHASE_RST;
	logic [qstr_pkg::GPER_W-1:0] gain_period = qstr_pkg::GAIN_PER_RST;
	longint            raw_i = 0;
	longint            raw_q = 0;
	bit                have_raw = 1'b0;
	longint            strobe_pos = 0;
	longint            omega = longint'(qstr_pkg::SPS_RST) << qstr_pkg::FRAC_W;
	longint            prev_sym_i = 0;
	longint            prev_sym_q = 0;
	bit                prev_neg_i = 1'b0;
	bit                prev_neg_q = 1'b0;
	bit                prev_valid = 1'b0;

	qpsk_symbol_timing_recovery dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// round half up, then drop n fraction bits
	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint sps_clamped();
		longint s;
		s = longint'(sps_reg);
		if (s < 2) s = 2;
		if (s > 64) s = 64;
		return s;
	endfunction

	function automatic void apply_reg(logic [qstr_pkg::CFG_IDX_W-1:0] idx,
			logic [qstr_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			qstr_pkg::CFG_SPS: begin
				sps_reg = val[qstr_pkg::SPS_W-1:0];
				omega = sps_clamped() << qstr_pkg::FRAC_W;
			end
			qstr_pkg::CFG_GAIN_PHASE: begin
				gain_phase = val[qstr_pkg::GAIN_W-1:0];
			end
			qstr_pkg::CFG_GAIN_PERIOD: begin
				gain_period = val[qstr_pkg::GPER_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Work out the symbols that one sample word releases
	function automatic void predict_symbols(logic [31:0] word);
		longint cur_i, cur_q, si, sq, cdi, cdq, pdi, pdq, acc, err, sps, lo, hi, adv;
		int n;
		bit holding;
		symbol_t held;
		cur_i = longint'($signed(word[15:0]));
		cur_q = longint'($signed(word[31:16]));
		n = 0;
		holding = 1'b0;
		held = '0;
		if (!have_raw) begin
			raw_i = cur_i;
			raw_q = cur_q;
			have_raw = 1'b1;
			return;
		end
		sps = sps_clamped();
		while (strobe_pos < ONE_UI && n < 2) begin
			si = raw_i + round_shift(strobe_pos * (cur_i - raw_i), qstr_pkg::FRAC_W);
			sq = raw_q + round_shift(strobe_pos * (cur_q - raw_q), qstr_pkg::FRAC_W);
			cdi = (si >= 0) ? 1 : -1;
			cdq = (sq >= 0) ? 1 : -1;
			pdi = prev_valid ? (prev_neg_i ? -1 : 1) : 0;
			pdq = prev_valid ? (prev_neg_q ? -1 : 1) : 0;
			acc = pdi * si + pdq * sq - cdi * prev_sym_i - cdq * prev_sym_q;
			err = round_shift(acc * longint'(qstr_pkg::INV_SQRT2_Q24),
				qstr_pkg::SAMPLE_W - 1);

			// integral path, then clamp omega to half..one and a half symbols
			omega += round_shift(longint'(gain_period) * err,
				2 * qstr_pkg::GAIN_W - qstr_pkg::FRAC_W);
			lo = sps << (qstr_pkg::FRAC_W - 1);
			hi = (sps * 3) << (qstr_pkg::FRAC_W - 1);
			if (omega < lo) omega = lo;
			if (omega > hi) omega = hi;

			// proportional path, advance held within half..two symbols
			adv = omega + round_shift(longint'(gain_phase) * err,
				2 * qstr_pkg::GAIN_W - qstr_pkg::FRAC_W);
			hi = sps << (qstr_pkg::FRAC_W + 1);
			if (adv < lo) adv = lo;
			if (adv > hi) adv = hi;

			prev_sym_i = si;
			prev_sym_q = sq;
			prev_neg_i = (cdi < 0);
			prev_neg_q = (cdq < 0);
			prev_valid = 1'b1;

			if (holding) symbols_due.insert(symbols_due.size(), held);
			held.sym_i = si[qstr_pkg::SAMPLE_W-1:0];
			held.sym_q = sq[qstr_pkg::SAMPLE_W-1:0];
			held.last = 1'b0;
			holding = 1'b1;
			n++;
			strobe_pos += adv;
		end
		if (holding) begin
			held.last = 1'b1;
			symbols_due.insert(symbols_due.size(), held);
		end
		strobe_pos = (strobe_pos >= ONE_UI) ? strobe_pos - ONE_UI : 0;
		raw_i = cur_i;
		raw_q = cur_q;
	endfunction

	// mostly no pause, some short ones, a few long
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70) return 0;
		if (r < 92) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] clip16(int v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic void put_sample(int i, int q);
		samples_pending.insert(samples_pending.size(), {clip16(q), clip16(i)});
	endfunction

	function automatic int pick_level();
		int a;
		a = int'($urandom_range(4000, 32767));
		return $urandom_range(0, 1) ? a : -a;
	endfunction

	// Mostly ramps between QPSK points with noise, the rest raw words
	task automatic queue_traffic(int count);
		int made, k, span, tgt_i, tgt_q, cur_i, cur_q;
		made = 0;
		cur_i = 0;
		cur_q = 0;
		while (made < count) begin
			if ($urandom_range(0, 3) == 0) begin
				samples_pending.insert(samples_pending.size(), $urandom);
				made++;
			end else begin
				span = int'(sps_clamped());
				tgt_i = pick_level();
				tgt_q = pick_level();
				for (k = 1; k <= span; k++) begin
					put_sample(cur_i + (tgt_i - cur_i) * k / span
						+ int'($urandom_range(0, 1600)) - 800,
						cur_q + (tgt_q - cur_q) * k / span
						+ int'($urandom_range(0, 1600)) - 800);
				end
				made += span;
				cur_i = tgt_i;
				cur_q = tgt_q;
			end
		end
	endtask

	// Hold until every word is in and every symbol is out, then let the block drain
	task automatic settle();
		while (samples_pending.size() != 0 || s_axis_tvalid || symbols_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [qstr_pkg::CFG_IDX_W-1:0] idx,
			logic [qstr_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		apply_reg(idx, val);
	endtask

	// Sample driver: present the next word once the slot is free
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			in_pause <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) predict_symbols(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (in_pause != 0) begin
					s_axis_tvalid <= 1'b0;
					in_pause <= in_pause - 1;
				end else if (samples_pending.size() != 0) begin
					s_axis_tdata <= samples_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					in_pause <= pick_pause();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Symbol monitor: check each word against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		symbol_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_pause <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (symbols_due.size() == 0) begin
					$error("unexpected symbol: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
					errors++;
				end else begin
					want = symbols_due.pop_front();
					if (m_axis_tdata[15:0] !== want.sym_i) begin
						$error("symbol_i mismatch: expected %0d, actual %0d",
							$signed(want.sym_i), $signed(m_axis_tdata[15:0]));
						errors++;
					end
					if (m_axis_tdata[31:16] !== want.sym_q) begin
						$error("symbol_q mismatch: expected %0d, actual %0d",
							$signed(want.sym_q), $signed(m_axis_tdata[31:16]));
						errors++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last mismatch: expected %b, actual %b", want.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if (out_pause != 0) begin
				m_axis_tready <= 1'b0;
				out_pause <= out_pause - 1;
			end else begin
				out_draw = pick_pause();
				m_axis_tready <= (out_draw == 0);
				out_pause <= (out_draw == 0) ? 0 : out_draw - 1;
			end
		end
	end

	// Watchdog: end the run if no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// first sample only stored, first strobe on it with no earlier decision
		put_sample(-32768, 32767);
		put_sample(32767, -32768);   put_sample(32767, 32767);   put_sample(-32768, -32768);
		put_sample(0, 0);            put_sample(0, 0);           put_sample(0, 0);
		put_sample(0, 0);            put_sample(0, 0);           put_sample(-1, 0);
		put_sample(0, -1);           put_sample(1, 1);           put_sample(-1, -1);
		put_sample(32767, 32767);    put_sample(32767, 32767);   put_sample(-32768, 32767);
		put_sample(-32768, 32767);   put_sample(21845, -21846);  put_sample(-21846, 21845);
		put_sample(32767, -32768);   put_sample(32767, -32768);  put_sample(-32768, -32768);
		put_sample(-32768, -32768);  put_sample(0, 0);           put_sample(0, 0);
		queue_traffic(250);
		settle();

		// fastest rate with both gains at full scale to hit every clamp
		write_reg(qstr_pkg::CFG_SPS, 24'd2);
		write_reg(qstr_pkg::CFG_GAIN_PHASE, 24'hFFFFFF);
		write_reg(qstr_pkg::CFG_GAIN_PERIOD, 24'h7FFFFF);
		queue_traffic(160);
		settle();

		// rate below range acts as two; smallest gains; back-to-back words
		write_reg(qstr_pkg::CFG_SPS, 24'd0);
		write_reg(qstr_pkg::CFG_GAIN_PHASE, 24'd1);
		write_reg(qstr_pkg::CFG_GAIN_PERIOD, 24'd0);
		quiet = 1'b1;
		queue_traffic(120);
		settle();
		quiet = 1'b0;

		// slowest rate with default gains
		write_reg(qstr_pkg::CFG_SPS, 24'd64);
		write_reg(qstr_pkg::CFG_GAIN_PHASE, 24'(qstr_pkg::GAIN_PHASE_RST));
		write_reg(qstr_pkg::CFG_GAIN_PERIOD, 24'(qstr_pkg::GAIN_PER_RST));
		queue_traffic(200);
		settle();

		// rate above range acts as sixty-four
		write_reg(CFG_SPARE, 24'hA5A5A5);
		write_reg(qstr_pkg::CFG_SPS, 24'd127);
		queue_traffic(80);
		settle();

		write_reg(qstr_pkg::CFG_SPS, 24'd1);
		write_reg(qstr_pkg::CFG_GAIN_PHASE, 24'd4194304);
		write_reg(qstr_pkg::CFG_GAIN_PERIOD, 24'd4194304);
		queue_traffic(80);
		settle();

		write_reg(qstr_pkg::CFG_SPS, 24'd8);
		write_reg(qstr_pkg::CFG_GAIN_PHASE, 24'($urandom_range(1, 24'hFFFFFF)));
		write_reg(qstr_pkg::CFG_GAIN_PERIOD, 24'($urandom_range(0, 23'h7FFFFF)));
		queue_traffic(250);
		settle();

		write_reg(qstr_pkg::CFG_SPS, 24'd3);
		write_reg(qstr_pkg::CFG_GAIN_PHASE, 24'd1677722);
		write_reg(qstr_pkg::CFG_GAIN_PERIOD, 24'd41944);
		queue_traffic(200);
		settle();

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
